### rtl/tfv_pkg.sv
`timescale 1ns / 1ps

package tfv_pkg;

    localparam int DEF_PEER_COUNT      = 3;
    localparam int DEF_MAX_FRAME_BYTES = 250;
    localparam int PEER_SLOTS          = 3;
    localparam int QUEUE_DEPTH         = 2;

    localparam int HDR_BYTES = 10;
    localparam int TEL_BYTES = 13;
    localparam int ADDR_W    = 48;
    localparam int REG_IDX_W = 2;

    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [7:0]  MAGIC          = 8'hA5;
    localparam logic [7:0]  VERSION        = 8'h01;
    localparam logic [7:0]  TYPE_TELEMETRY = 8'd2;
    localparam logic [7:0]  TYPE_ACK       = 8'd3;
    localparam logic [15:0] TEL_LEN        = 16'd13;

    localparam logic [REG_IDX_W-1:0] REG_PEER_A = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PEER_B = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PEER_C = 2'd2;

    typedef enum logic [2:0] {
        ST_TELEMETRY  = 3'd0,
        ST_ACK_SEEN   = 3'd1,
        ST_OTHER      = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_SHORT      = 3'd4,
        ST_BAD_HEADER = 3'd5,
        ST_BAD_CRC    = 3'd6
    } status_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    localparam logic [15:0] ACK_SEED =
        crc_byte(crc_byte(crc_byte(CRC_INIT, MAGIC), VERSION), TYPE_ACK);

    typedef struct packed {
        logic                    peer_hit;
        logic [1:0]              peer_idx;
        logic                    short_frame;
        logic                    header_bad;
        logic [15:0]             check_calc;
        logic [15:0]             check_rx;
        logic [7:0]              msg_type;
        logic                    tel_len;
        logic [7:0]              channel;
        logic [15:0]             seq_num;
        logic [15:0]             ack_check;
        logic [TEL_BYTES*8-1:0]  payload;
    } frame_summary_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  peer_index;
        logic [7:0]  frame_channel;
        logic [15:0] frame_sequence;
        logic [15:0] applied_brightness;
        logic [7:0]  applied_state;
        logic [15:0] half_voltage_mv;
        logic [31:0] operating_hours;
        logic [31:0] last_charged;
        logic [15:0] ack_check;
    } frame_result_t;

endpackage

### rtl/telemetry_frame_validator.sv
`timescale 1ns / 1ps

// Checks received frames fed one byte per cycle and gives one verdict per frame,
// on the request that carries the frame-end mark. The header and payload CRC16 update
// is a single-byte unrolled step, so a byte is accepted on every clock while the result
// side keeps up. A frame's summary is written into the queue when its final byte is
// taken and then loaded into the verdict register, which offers it on the result
// channel; the two-entry queue between the byte front end and the verdict register
// absorbs result-side stalls, and the input stalls only once both entries are waiting.
// Peer address registers may be written only while no frame is in flight.
module telemetry_frame_validator #(
    parameter int PEER_COUNT      = tfv_pkg::DEF_PEER_COUNT,
    parameter int MAX_FRAME_BYTES = tfv_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tfv_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [tfv_pkg::ADDR_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_frame_byte,
    input  logic                          s_frame_end,
    input  logic [tfv_pkg::ADDR_W-1:0]    s_source_address,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [1:0]                    m_peer_index,
    output logic [7:0]                    m_frame_channel,
    output logic [15:0]                   m_frame_sequence,
    output logic [15:0]                   m_applied_brightness,
    output logic [7:0]                    m_applied_state,
    output logic [15:0]                   m_half_voltage_mv,
    output logic [31:0]                   m_operating_hours,
    output logic [31:0]                   m_last_charged,
    output logic [15:0]                   m_ack_check
);
    import tfv_pkg::*;

    frame_summary_t push_data, pop_data;
    frame_result_t  result;
    logic           push_valid, push_ready, pop_valid, pop_ready;

    tfv_front #(
        .PEER_COUNT      (PEER_COUNT),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_byte     (s_frame_byte),
        .s_frame_end      (s_frame_end),
        .s_source_address (s_source_address),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_data        (push_data)
    );

    tfv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tfv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result)
    );

    assign m_status             = result.status;
    assign m_peer_index         = result.peer_index;
    assign m_frame_channel      = result.frame_channel;
    assign m_frame_sequence     = result.frame_sequence;
    assign m_applied_brightness = result.applied_brightness;
    assign m_applied_state      = result.applied_state;
    assign m_half_voltage_mv    = result.half_voltage_mv;
    assign m_operating_hours    = result.operating_hours;
    assign m_last_charged       = result.last_charged;
    assign m_ack_check          = result.ack_check;

endmodule

### rtl/tfv_front.sv
`timescale 1ns / 1ps

module tfv_front #(
    parameter int PEER_COUNT      = tfv_pkg::DEF_PEER_COUNT,
    parameter int MAX_FRAME_BYTES = tfv_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tfv_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [tfv_pkg::ADDR_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_frame_byte,
    input  logic                          s_frame_end,
    input  logic [tfv_pkg::ADDR_W-1:0]    s_source_address,
    output logic                          push_valid,
    input  logic                          push_ready,
    output tfv_pkg::frame_summary_t       push_data
);
    import tfv_pkg::*;

    localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 2);

    logic [ADDR_W-1:0]  peer_reg [PEER_COUNT];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_fin;
    logic [15:0]        hcrc_reg, pcrc_reg, ack_reg;
    logic [15:0]        hcrc_next, pcrc_next, ack_next;
    logic [7:0]         hdr_reg  [HDR_BYTES];
    logic [7:0]         hdr_next [HDR_BYTES];
    logic [7:0]         pay_reg  [TEL_BYTES];
    logic [7:0]         pay_next [TEL_BYTES];
    logic               accept;
    logic               hdr_phase;
    logic               zero_field;
    logic [15:0]        crc_base, crc_out;
    logic [7:0]         crc_data;
    logic               ack_upd;
    logic [15:0]        ack_base, ack_out;
    logic [7:0]         ack_data;
    logic               peer_hit;
    logic [1:0]         peer_idx;
    logic [15:0]        plen;
    logic               len_ok;

    assign s_ready    = push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = s_valid && s_frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < PEER_COUNT; g++) begin
                peer_reg[g] <= '0;
            end
        end else if (cfg_wr_en) begin
            for (int g = 0; g < PEER_COUNT; g++) begin
                if (cfg_index == REG_IDX_W'(g)) begin
                    peer_reg[g] <= cfg_wr_data;
                end
            end
        end
    end

    always_comb begin
        peer_hit = 1'b0;
        peer_idx = '0;
        for (int g = PEER_COUNT - 1; g >= 0; g--) begin
            if (peer_reg[g] == s_source_address) begin
                peer_hit = 1'b1;
                peer_idx = 2'(g);
            end
        end
    end

    assign hdr_phase  = count_reg < COUNT_W'(HDR_BYTES);
    assign zero_field = count_reg == COUNT_W'(8) || count_reg == COUNT_W'(9);
    assign crc_base   = hdr_phase ? hcrc_reg : pcrc_reg;
    assign crc_data   = (hdr_phase && zero_field) ? 8'h00 : s_frame_byte;
    assign crc_out    = crc_byte(crc_base, crc_data);
    assign hcrc_next  = hdr_phase ? crc_out : hcrc_reg;
    assign pcrc_next  = hdr_phase ? pcrc_reg : crc_out;

    assign ack_upd  = count_reg >= COUNT_W'(3) && count_reg <= COUNT_W'(9);
    assign ack_base = (count_reg == COUNT_W'(3)) ? ACK_SEED : ack_reg;
    assign ack_data = (count_reg == COUNT_W'(3) || count_reg == COUNT_W'(6) ||
                       count_reg == COUNT_W'(7)) ? s_frame_byte : 8'h00;
    assign ack_out  = crc_byte(ack_base, ack_data);
    assign ack_next = ack_upd ? ack_out : ack_reg;

    assign count_fin = (count_reg <= COUNT_W'(MAX_FRAME_BYTES)) ?
                       count_reg + COUNT_W'(1) : count_reg;

    always_comb begin
        for (int k = 0; k < HDR_BYTES; k++) begin
            hdr_next[k] = (count_reg == COUNT_W'(k)) ? s_frame_byte : hdr_reg[k];
        end
        for (int k = 0; k < TEL_BYTES; k++) begin
            pay_next[k] = (count_reg == COUNT_W'(k + HDR_BYTES)) ?
                          s_frame_byte : pay_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < HDR_BYTES; k++) begin
                hdr_reg[k] <= hdr_next[k];
            end
            for (int k = 0; k < TEL_BYTES; k++) begin
                pay_reg[k] <= pay_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            hcrc_reg  <= CRC_INIT;
            pcrc_reg  <= CRC_INIT;
            ack_reg   <= CRC_INIT;
        end else if (accept) begin
            if (s_frame_end) begin
                count_reg <= '0;
                hcrc_reg  <= CRC_INIT;
                pcrc_reg  <= CRC_INIT;
            end else begin
                count_reg <= count_fin;
                hcrc_reg  <= hcrc_next;
                pcrc_reg  <= pcrc_next;
            end
            ack_reg <= ack_next;
        end
    end

    assign plen   = {hdr_next[5], hdr_next[4]};
    assign len_ok = ({1'b0, plen} + 17'(HDR_BYTES)) == 17'(count_fin);

    always_comb begin
        push_data.peer_hit    = peer_hit;
        push_data.peer_idx    = peer_idx;
        push_data.short_frame = count_fin < COUNT_W'(HDR_BYTES);
        push_data.header_bad  = count_fin > COUNT_W'(MAX_FRAME_BYTES) ||
                                hdr_next[0] != MAGIC || hdr_next[1] != VERSION ||
                                !len_ok;
        push_data.check_calc  = hcrc_next ^ pcrc_next;
        push_data.check_rx    = {hdr_next[9], hdr_next[8]};
        push_data.msg_type    = hdr_next[2];
        push_data.tel_len     = plen == TEL_LEN;
        push_data.channel     = hdr_next[3];
        push_data.seq_num     = {hdr_next[7], hdr_next[6]};
        push_data.ack_check   = ack_next;
        for (int k = 0; k < TEL_BYTES; k++) begin
            push_data.payload[8*k +: 8] = pay_next[k];
        end
    end

endmodule

### rtl/tfv_queue.sv
`timescale 1ns / 1ps

module tfv_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  tfv_pkg::frame_summary_t push_data,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output tfv_pkg::frame_summary_t pop_data
);
    import tfv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    frame_summary_t     slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     fill_reg;
    logic               do_push, do_pop;

    assign push_ready = fill_reg != (PTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + (PTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - (PTR_W + 1)'(1);
            end
        end
    end

endmodule

### rtl/tfv_back.sv
`timescale 1ns / 1ps

module tfv_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  tfv_pkg::frame_summary_t pop_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output tfv_pkg::frame_result_t  m_result
);
    import tfv_pkg::*;

    frame_result_t res_reg, res_next;
    logic          valid_reg;
    logic [7:0]    p [TEL_BYTES];

    assign pop_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_result  = res_reg;

    always_comb begin
        for (int k = 0; k < TEL_BYTES; k++) begin
            p[k] = pop_data.payload[8*k +: 8];
        end
    end

    always_comb begin
        res_next = '0;
        if (!pop_data.peer_hit) begin
            res_next.status = ST_UNKNOWN;
        end else begin
            res_next.peer_index = pop_data.peer_idx;
            if (pop_data.short_frame) begin
                res_next.status = ST_SHORT;
            end else begin
                res_next.frame_channel  = pop_data.channel;
                res_next.frame_sequence = pop_data.seq_num;
                if (pop_data.header_bad) begin
                    res_next.status = ST_BAD_HEADER;
                end else if (pop_data.check_calc != pop_data.check_rx) begin
                    res_next.status = ST_BAD_CRC;
                end else if (pop_data.msg_type == TYPE_ACK) begin
                    res_next.status = ST_ACK_SEEN;
                end else if (pop_data.msg_type == TYPE_TELEMETRY && pop_data.tel_len) begin
                    res_next.status             = ST_TELEMETRY;
                    res_next.applied_brightness = {p[1], p[0]};
                    res_next.applied_state      = p[2];
                    res_next.half_voltage_mv    = {p[4], p[3]};
                    res_next.operating_hours    = {p[8], p[7], p[6], p[5]};
                    res_next.last_charged       = {p[12], p[11], p[10], p[9]};
                    res_next.ack_check          = pop_data.ack_check;
                end else begin
                    res_next.status = ST_OTHER;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop_ready) begin
            valid_reg <= pop_valid;
        end
    end

endmodule

### sim/telemetry_frame_checker.sv
`timescale 1ns / 1ps

module telemetry_frame_checker
    import tfv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [7:0]           s_frame_byte,
    input  logic                 s_frame_end,
    input  logic [ADDR_W-1:0]    s_source_address,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [2:0]           m_status,
    input  logic [1:0]           m_peer_index,
    input  logic [7:0]           m_frame_channel,
    input  logic [15:0]          m_frame_sequence,
    input  logic [15:0]          m_applied_brightness,
    input  logic [7:0]           m_applied_state,
    input  logic [15:0]          m_half_voltage_mv,
    input  logic [31:0]          m_operating_hours,
    input  logic [31:0]          m_last_charged,
    input  logic [15:0]          m_ack_check,
    output int                   fail_count,
    output int                   verdicts_owed
);

    logic [ADDR_W-1:0] peer_tab [PEER_SLOTS];
    int                byte_cnt;
    logic [7:0]        hdr_bytes [HDR_BYTES];
    logic [7:0]        tel_bytes [TEL_BYTES];
    logic [15:0]       hdr_crc;
    logic [15:0]       pay_crc;
    frame_result_t     verdict_q [$];
    frame_result_t     verdict;
    frame_result_t     want;
    int                peer_hit;
    logic [15:0]       len_field;
    logic [15:0]       seq_field;
    logic [15:0]       rx_check;
    logic [15:0]       ack_crc;
    logic [7:0]        ack_hdr [HDR_BYTES];
    int                mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] r;
        r = crc ^ {data, 8'h00};
        repeat (8) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    function automatic void restart_frame();
        byte_cnt = 0;
        hdr_crc  = CRC_INIT;
        pay_crc  = CRC_INIT;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] expected,
                                          input logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, name, expected, actual);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (peer_tab[i]) peer_tab[i] = '0;
            restart_frame();
            verdict_q.delete();
        end else begin
            if (cfg_wr_en && cfg_index < PEER_SLOTS) begin
                peer_tab[cfg_index] = cfg_wr_data;
            end

            if (s_valid && s_ready) begin
                if (byte_cnt < HDR_BYTES) begin
                    hdr_bytes[byte_cnt] = s_frame_byte;
                    hdr_crc = crc_update(hdr_crc, (byte_cnt >= 8) ? 8'h00 : s_frame_byte);
                end else begin
                    if (byte_cnt < HDR_BYTES + TEL_BYTES) begin
                        tel_bytes[byte_cnt - HDR_BYTES] = s_frame_byte;
                    end
                    pay_crc = crc_update(pay_crc, s_frame_byte);
                end
                if (byte_cnt <= DEF_MAX_FRAME_BYTES) byte_cnt++;

                if (s_frame_end) begin
                    verdict  = '0;
                    peer_hit = -1;
                    for (int j = DEF_PEER_COUNT - 1; j >= 0; j--) begin
                        if (peer_tab[j] == s_source_address) peer_hit = j;
                    end
                    if (peer_hit < 0) begin
                        verdict.status = ST_UNKNOWN;
                    end else begin
                        verdict.peer_index = 2'(peer_hit);
                        if (byte_cnt < HDR_BYTES) begin
                            verdict.status = ST_SHORT;
                        end else begin
                            len_field = {hdr_bytes[5], hdr_bytes[4]};
                            seq_field = {hdr_bytes[7], hdr_bytes[6]};
                            rx_check  = {hdr_bytes[9], hdr_bytes[8]};
                            verdict.frame_channel  = hdr_bytes[3];
                            verdict.frame_sequence = seq_field;
                            if (byte_cnt > DEF_MAX_FRAME_BYTES || hdr_bytes[0] != MAGIC ||
                                hdr_bytes[1] != VERSION ||
                                int'(len_field) + HDR_BYTES != byte_cnt) begin
                                verdict.status = ST_BAD_HEADER;
                            end else if ((hdr_crc ^ pay_crc) != rx_check) begin
                                verdict.status = ST_BAD_CRC;
                            end else if (hdr_bytes[2] == TYPE_ACK) begin
                                verdict.status = ST_ACK_SEEN;
                            end else if (hdr_bytes[2] == TYPE_TELEMETRY &&
                                         len_field == TEL_LEN) begin
                                ack_hdr = '{MAGIC, VERSION, TYPE_ACK, hdr_bytes[3], 8'h00, 8'h00,
                                            seq_field[7:0], seq_field[15:8], 8'h00, 8'h00};
                                ack_crc = CRC_INIT;
                                foreach (ack_hdr[k]) ack_crc = crc_update(ack_crc, ack_hdr[k]);
                                verdict.status             = ST_TELEMETRY;
                                verdict.applied_brightness = {tel_bytes[1], tel_bytes[0]};
                                verdict.applied_state      = tel_bytes[2];
                                verdict.half_voltage_mv    = {tel_bytes[4], tel_bytes[3]};
                                verdict.operating_hours    = {tel_bytes[8], tel_bytes[7],
                                                              tel_bytes[6], tel_bytes[5]};
                                verdict.last_charged       = {tel_bytes[12], tel_bytes[11],
                                                              tel_bytes[10], tel_bytes[9]};
                                verdict.ack_check          = ack_crc;
                            end else begin
                                verdict.status = ST_OTHER;
                            end
                        end
                    end
                    verdict_q.push_back(verdict);
                    restart_frame();
                end
            end

            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none actual status %0d",
                             $time, m_status);
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    compare_field("status", want.status, m_status);
                    compare_field("peer_index", want.peer_index, m_peer_index);
                    compare_field("frame_channel", want.frame_channel, m_frame_channel);
                    compare_field("frame_sequence", want.frame_sequence, m_frame_sequence);
                    compare_field("applied_brightness", want.applied_brightness,
                                  m_applied_brightness);
                    compare_field("applied_state", want.applied_state, m_applied_state);
                    compare_field("half_voltage_mv", want.half_voltage_mv, m_half_voltage_mv);
                    compare_field("operating_hours", want.operating_hours, m_operating_hours);
                    compare_field("last_charged", want.last_charged, m_last_charged);
                    compare_field("ack_check", want.ack_check, m_ack_check);
                end
            end
        end
        verdicts_owed <= verdict_q.size();
    end

endmodule

### sim/tb_telemetry_frame_validator.sv
`timescale 1ns / 1ps

module tb_telemetry_frame_validator;
    import tfv_pkg::*;

    localparam int SETTLE_CYCLES = 8;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 cfg_wr_en        = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index        = REG_PEER_A;
    logic [ADDR_W-1:0]    cfg_wr_data      = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_frame_byte     = '0;
    logic                 s_frame_end      = 1'b0;
    logic [ADDR_W-1:0]    s_source_address = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [2:0]           m_status;
    logic [1:0]           m_peer_index;
    logic [7:0]           m_frame_channel;
    logic [15:0]          m_frame_sequence;
    logic [15:0]          m_applied_brightness;
    logic [7:0]           m_applied_state;
    logic [15:0]          m_half_voltage_mv;
    logic [31:0]          m_operating_hours;
    logic [31:0]          m_last_charged;
    logic [15:0]          m_ack_check;
    int                   fail_count;
    int                   verdicts_owed;

    logic [7:0]        frame_bytes [$];
    logic [ADDR_W-1:0] peer_cfg [PEER_SLOTS];
    int                burst_left   = 0;
    int                bytes_sent   = 0;
    int                ready_window = 0;
    int                ready_odds   = 100;

    telemetry_frame_validator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_frame_byte(s_frame_byte),
        .s_frame_end(s_frame_end), .s_source_address(s_source_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_peer_index(m_peer_index), .m_frame_channel(m_frame_channel),
        .m_frame_sequence(m_frame_sequence), .m_applied_brightness(m_applied_brightness),
        .m_applied_state(m_applied_state), .m_half_voltage_mv(m_half_voltage_mv),
        .m_operating_hours(m_operating_hours), .m_last_charged(m_last_charged),
        .m_ack_check(m_ack_check)
    );

    telemetry_frame_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_frame_byte(s_frame_byte),
        .s_frame_end(s_frame_end), .s_source_address(s_source_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_peer_index(m_peer_index), .m_frame_channel(m_frame_channel),
        .m_frame_sequence(m_frame_sequence), .m_applied_brightness(m_applied_brightness),
        .m_applied_state(m_applied_state), .m_half_voltage_mv(m_half_voltage_mv),
        .m_operating_hours(m_operating_hours), .m_last_charged(m_last_charged),
        .m_ack_check(m_ack_check),
        .fail_count(fail_count), .verdicts_owed(verdicts_owed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (ready_window == 0) begin
            ready_window = $urandom_range(10, 80);
            case ($urandom_range(0, 3))
                0: ready_odds = 100;
                1: ready_odds = 70;
                2: ready_odds = 30;
                default: ready_odds = 5;
            endcase
        end
        ready_window--;
        m_ready <= ($urandom_range(1, 100) <= ready_odds);
    end

    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
        for (int i = 7; i >= 0; i--) begin
            if (c[15] ^ d[i]) c = {c[14:0], 1'b0} ^ CRC_POLY;
            else c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[ADDR_W-1:0];
    endfunction

    function automatic void seal_frame();
        logic [15:0] hc;
        logic [15:0] pc;
        logic [15:0] ck;
        hc = CRC_INIT;
        pc = CRC_INIT;
        foreach (frame_bytes[i]) begin
            if (i < 8) hc = crc16_next(hc, frame_bytes[i]);
            else if (i < HDR_BYTES) hc = crc16_next(hc, 8'h00);
            else pc = crc16_next(pc, frame_bytes[i]);
        end
        ck = hc ^ pc;
        frame_bytes[8] = ck[7:0];
        frame_bytes[9] = ck[15:8];
    endfunction

    function automatic void build_frame(input logic [7:0] kind, input int pay_len);
        logic [7:0]  head [HDR_BYTES];
        logic [15:0] seq;
        logic [7:0]  chan;
        chan = 8'($urandom);
        seq  = 16'($urandom);
        head = '{MAGIC, VERSION, kind, chan, 8'(pay_len), 8'(pay_len >> 8),
                 seq[7:0], seq[15:8], 8'h00, 8'h00};
        frame_bytes.delete();
        foreach (head[i]) frame_bytes.push_back(head[i]);
        repeat (pay_len) frame_bytes.push_back(8'($urandom));
        seal_frame();
    endfunction

    function automatic void pin_frame(input logic [7:0] chan, input logic [15:0] seq,
                                      input logic [7:0] fill);
        frame_bytes[3] = chan;
        frame_bytes[6] = seq[7:0];
        frame_bytes[7] = seq[15:8];
        for (int i = HDR_BYTES; i < frame_bytes.size(); i++) frame_bytes[i] = fill;
        seal_frame();
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic last,
                             input logic [ADDR_W-1:0] src);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        bytes_sent++;
        s_valid          <= 1'b1;
        s_frame_byte     <= value;
        s_frame_end      <= last;
        s_source_address <= src;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_frame(input logic [ADDR_W-1:0] src, input bit vary);
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(frame_bytes[i], i == n - 1, (vary && i != n - 1) ? rand_addr() : src);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (verdicts_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_peer(input logic [REG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        peer_cfg[idx] = value;
    endtask

    task automatic send_random_frame();
        int                pick;
        int                pay_len;
        logic [15:0]       bad_len;
        logic [ADDR_W-1:0] src;
        bit                vary;
        pick = $urandom_range(0, 99);
        src  = peer_cfg[$urandom_range(0, PEER_SLOTS - 1)];
        vary = ($urandom_range(0, 9) == 0);
        if (pick < 35) begin
            build_frame(TYPE_TELEMETRY, TEL_BYTES);
        end else if (pick < 45) begin
            build_frame(TYPE_ACK, $urandom_range(0, 16));
        end else if (pick < 55) begin
            build_frame(8'($urandom), $urandom_range(0, 20));
        end else if (pick < 60) begin
            build_frame(TYPE_TELEMETRY, $urandom_range(0, 20));
        end else if (pick < 67) begin
            build_frame(TYPE_TELEMETRY, TEL_BYTES);
            frame_bytes[8 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        end else if (pick < 75) begin
            build_frame(8'($urandom_range(0, 4)), $urandom_range(0, 16));
            pay_len = frame_bytes.size() - HDR_BYTES;
            case ($urandom_range(0, 2))
                0: frame_bytes[0] ^= 8'($urandom_range(1, 255));
                1: frame_bytes[1] ^= 8'($urandom_range(1, 255));
                default: begin
                    bad_len = 16'(pay_len + $urandom_range(1, 65535));
                    frame_bytes[4] = bad_len[7:0];
                    frame_bytes[5] = bad_len[15:8];
                end
            endcase
            seal_frame();
        end else if (pick < 82) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, HDR_BYTES - 1)) frame_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 1) frame_bytes[0] = MAGIC;
        end else if (pick < 89) begin
            build_frame(TYPE_TELEMETRY, TEL_BYTES);
            do src = rand_addr();
            while (src == peer_cfg[0] || src == peer_cfg[1] || src == peer_cfg[2]);
        end else if (pick < 91) begin
            build_frame(8'($urandom_range(0, 4)), $urandom_range(239, 246));
        end else begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 30)) frame_bytes.push_back(8'($urandom));
            vary = 1'b1;
        end
        send_frame(src, vary);
    endtask

    initial begin
        int                phase_start;
        logic [ADDR_W-1:0] shared;
        foreach (peer_cfg[i]) peer_cfg[i] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        frame_bytes.delete();
        frame_bytes.push_back(MAGIC);
        send_frame('0, 1'b0);
        build_frame(TYPE_ACK, 0);
        send_frame(48'h0000_0000_0001, 1'b0);

        settle();
        write_peer(REG_PEER_A, '1);
        write_peer(REG_PEER_B, '0);
        write_peer(REG_PEER_C, 48'h5AC3_0F96_A55A);

        build_frame(TYPE_TELEMETRY, TEL_BYTES);
        pin_frame(8'h00, 16'h0000, 8'h00);
        send_frame(peer_cfg[0], 1'b0);
        build_frame(TYPE_TELEMETRY, TEL_BYTES);
        pin_frame(8'hFF, 16'hFFFF, 8'hFF);
        send_frame(peer_cfg[2], 1'b1);
        build_frame(TYPE_ACK, 0);
        send_frame(peer_cfg[1], 1'b0);
        build_frame(8'hFF, 1);
        send_frame(peer_cfg[0], 1'b0);
        build_frame(TYPE_TELEMETRY, TEL_BYTES - 1);
        send_frame(peer_cfg[2], 1'b0);
        frame_bytes.delete();
        repeat (HDR_BYTES - 1) frame_bytes.push_back(MAGIC);
        send_frame(peer_cfg[1], 1'b0);
        build_frame(TYPE_TELEMETRY, TEL_BYTES);
        frame_bytes[0] = 8'h00;
        seal_frame();
        send_frame(peer_cfg[0], 1'b0);
        build_frame(TYPE_ACK, 0);
        frame_bytes[1] = 8'hFF;
        seal_frame();
        send_frame(peer_cfg[0], 1'b0);
        build_frame(TYPE_ACK, 2);
        frame_bytes[4] = 8'hFF;
        frame_bytes[5] = 8'hFF;
        seal_frame();
        send_frame(peer_cfg[1], 1'b0);
        build_frame(TYPE_TELEMETRY, TEL_BYTES);
        frame_bytes[9] ^= 8'h80;
        send_frame(peer_cfg[2], 1'b0);
        frame_bytes.delete();
        repeat (4) frame_bytes.push_back(8'($urandom));
        send_frame(48'h8000_0000_0000, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: begin
                    shared = rand_addr();
                    write_peer(REG_PEER_A, shared);
                    write_peer(REG_PEER_B, shared);
                    write_peer(REG_PEER_C, rand_addr());
                end
                1: begin
                    write_peer(REG_PEER_A, '0);
                    write_peer(REG_PEER_B, '1);
                    write_peer(REG_PEER_C, '0);
                end
                default: begin
                    write_peer(REG_PEER_A, rand_addr());
                    write_peer(REG_PEER_B, rand_addr());
                    write_peer(REG_PEER_C, rand_addr());
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 130) begin
                send_random_frame();
                if ($urandom_range(0, 14) == 0) settle();
            end
        end

        settle();
        if (fail_count == 0 && verdicts_owed == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
